// ===== sv/pavt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pavt_pkg
// Shared types, constants and the step program of the vertex thinning block.
// ----------------------------------------------------------------------------
package pavt_pkg;

   localparam int COORD_BITS = 16;
   localparam int COORD_W    = 16;
   localparam logic [COORD_W-1:0] COORD_MASK =
      COORD_W'((64'd1 << COORD_BITS) - 64'd1);

   localparam int VALUE_W = 32;
   localparam int COS_W   = 17;
   localparam int SCALE_W = 16;
   localparam int LIMB_W  = 32;
   localparam int PROD_W  = 64;
   localparam int ACC_W   = 192;
   localparam int STEP_W  = 6;

   localparam logic [STEP_W-1:0] LAST_STEP = 6'd40;

   localparam logic [COS_W-1:0]   COS_RESET   = 17'd65286;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd1;

   // register indexes on the csr port
   localparam logic [1:0] CSR_COS_TOL = 2'd0;
   localparam logic [1:0] CSR_PIXEL_W = 2'd1;
   localparam logic [1:0] CSR_PIXEL_H = 2'd2;

   typedef enum logic [1:0] {
      K_NOP = 2'd0,
      K_MUL = 2'd1,
      K_DOT = 2'd2,
      K_CMP = 2'd3
   } kind_type;

   // 32-bit operand limbs feeding the shared multiplier
   typedef enum logic [4:0] {
      SRC_DAX   = 5'd0,
      SRC_DAY   = 5'd1,
      SRC_DBX   = 5'd2,
      SRC_DBY   = 5'd3,
      SRC_PW    = 5'd4,
      SRC_PH    = 5'd5,
      SRC_AX    = 5'd6,
      SRC_AY    = 5'd7,
      SRC_BX    = 5'd8,
      SRC_BY    = 5'd9,
      SRC_CT    = 5'd10,
      SRC_CT2_0 = 5'd11,
      SRC_CT2_1 = 5'd12,
      SRC_A0    = 5'd13,
      SRC_A1    = 5'd14,
      SRC_A2    = 5'd15,
      SRC_B0    = 5'd16,
      SRC_B1    = 5'd17,
      SRC_B2    = 5'd18,
      SRC_C0    = 5'd19,
      SRC_C1    = 5'd20,
      SRC_C2    = 5'd21,
      SRC_C3    = 5'd22,
      SRC_D0    = 5'd23,
      SRC_D1    = 5'd24,
      SRC_D2    = 5'd25
   } src_type;

   typedef enum logic [3:0] {
      DST_NONE = 4'd0,
      DST_AX   = 4'd1,
      DST_AY   = 4'd2,
      DST_BX   = 4'd3,
      DST_BY   = 4'd4,
      DST_A    = 4'd5,
      DST_B    = 4'd6,
      DST_TX   = 4'd7,
      DST_TY   = 4'd8,
      DST_CT2  = 4'd9,
      DST_C    = 4'd10,
      DST_D2   = 4'd11,
      DST_R    = 4'd12
   } dst_type;

   typedef struct packed {
      kind_type   kind;
      src_type    xsel;
      src_type    ysel;
      logic [2:0] k;
      logic       first;
      dst_type    dst;
   } step_type;

   typedef struct packed {
      logic       mul;
      logic       first;
      logic [2:0] k;
      dst_type    dst;
   } mac_cmd_type;

   typedef struct packed {
      logic             we;
      dst_type          dst;
      logic [ACC_W-1:0] value;
   } wb_type;

   typedef struct packed {
      logic [COORD_W-1:0] older_col;
      logic [COORD_W-1:0] older_row;
      logic [COORD_W-1:0] middle_col;
      logic [COORD_W-1:0] middle_row;
      logic [COORD_W-1:0] new_col;
      logic [COORD_W-1:0] new_row;
   } win_type;

   typedef struct packed {
      logic [COS_W-1:0]   cos_tol;
      logic [SCALE_W-1:0] pixel_w;
      logic [SCALE_W-1:0] pixel_h;
   } cfg_type;

   typedef struct packed {
      logic done;
      logic keep;
   } eval_status_type;

   function automatic step_type mk_step(input kind_type kind, input src_type xs,
                                        input src_type ys, input logic [2:0] k,
                                        input logic first, input dst_type dst);
      step_type r;
      r.kind  = kind;
      r.xsel  = xs;
      r.ysel  = ys;
      r.k     = k;
      r.first = first;
      r.dst   = dst;
      return r;
   endfunction

   // step program: scaled deltas, squared lengths, dot terms, ct^2, ct^2*A, d^2, ct^2*A*B, compare
   function automatic step_type step_rom(input logic [STEP_W-1:0] s);
      step_type r;
      case (s)
         6'd0:  r = mk_step(K_MUL, SRC_DAX, SRC_PW, 3'd0, 1'b1, DST_AX);
         6'd1:  r = mk_step(K_MUL, SRC_DAY, SRC_PH, 3'd0, 1'b1, DST_AY);
         6'd2:  r = mk_step(K_MUL, SRC_DBX, SRC_PW, 3'd0, 1'b1, DST_BX);
         6'd3:  r = mk_step(K_MUL, SRC_DBY, SRC_PH, 3'd0, 1'b1, DST_BY);
         6'd4:  r = mk_step(K_MUL, SRC_AX, SRC_AX, 3'd0, 1'b1, DST_NONE);
         6'd5:  r = mk_step(K_MUL, SRC_AY, SRC_AY, 3'd0, 1'b0, DST_A);
         6'd6:  r = mk_step(K_MUL, SRC_BX, SRC_BX, 3'd0, 1'b1, DST_NONE);
         6'd7:  r = mk_step(K_MUL, SRC_BY, SRC_BY, 3'd0, 1'b0, DST_B);
         6'd8:  r = mk_step(K_MUL, SRC_AX, SRC_BX, 3'd0, 1'b1, DST_TX);
         6'd9:  r = mk_step(K_MUL, SRC_AY, SRC_BY, 3'd0, 1'b1, DST_TY);
         6'd10: r = mk_step(K_MUL, SRC_CT, SRC_CT, 3'd0, 1'b1, DST_CT2);
         6'd11: r = mk_step(K_DOT, SRC_DAX, SRC_DAX, 3'd0, 1'b0, DST_NONE);
         6'd12: r = mk_step(K_MUL, SRC_CT2_0, SRC_A0, 3'd0, 1'b1, DST_NONE);
         6'd13: r = mk_step(K_MUL, SRC_CT2_0, SRC_A1, 3'd1, 1'b0, DST_NONE);
         6'd14: r = mk_step(K_MUL, SRC_CT2_0, SRC_A2, 3'd2, 1'b0, DST_NONE);
         6'd15: r = mk_step(K_MUL, SRC_CT2_1, SRC_A0, 3'd1, 1'b0, DST_NONE);
         6'd16: r = mk_step(K_MUL, SRC_CT2_1, SRC_A1, 3'd2, 1'b0, DST_NONE);
         6'd17: r = mk_step(K_MUL, SRC_CT2_1, SRC_A2, 3'd3, 1'b0, DST_C);
         6'd18: r = mk_step(K_MUL, SRC_D0, SRC_D0, 3'd0, 1'b1, DST_NONE);
         6'd19: r = mk_step(K_MUL, SRC_D0, SRC_D1, 3'd1, 1'b0, DST_NONE);
         6'd20: r = mk_step(K_MUL, SRC_D0, SRC_D2, 3'd2, 1'b0, DST_NONE);
         6'd21: r = mk_step(K_MUL, SRC_D1, SRC_D0, 3'd1, 1'b0, DST_NONE);
         6'd22: r = mk_step(K_MUL, SRC_D1, SRC_D1, 3'd2, 1'b0, DST_NONE);
         6'd23: r = mk_step(K_MUL, SRC_D1, SRC_D2, 3'd3, 1'b0, DST_NONE);
         6'd24: r = mk_step(K_MUL, SRC_D2, SRC_D0, 3'd2, 1'b0, DST_NONE);
         6'd25: r = mk_step(K_MUL, SRC_D2, SRC_D1, 3'd3, 1'b0, DST_NONE);
         6'd26: r = mk_step(K_MUL, SRC_D2, SRC_D2, 3'd4, 1'b0, DST_D2);
         6'd27: r = mk_step(K_MUL, SRC_C0, SRC_B0, 3'd0, 1'b1, DST_NONE);
         6'd28: r = mk_step(K_MUL, SRC_C0, SRC_B1, 3'd1, 1'b0, DST_NONE);
         6'd29: r = mk_step(K_MUL, SRC_C0, SRC_B2, 3'd2, 1'b0, DST_NONE);
         6'd30: r = mk_step(K_MUL, SRC_C1, SRC_B0, 3'd1, 1'b0, DST_NONE);
         6'd31: r = mk_step(K_MUL, SRC_C1, SRC_B1, 3'd2, 1'b0, DST_NONE);
         6'd32: r = mk_step(K_MUL, SRC_C1, SRC_B2, 3'd3, 1'b0, DST_NONE);
         6'd33: r = mk_step(K_MUL, SRC_C2, SRC_B0, 3'd2, 1'b0, DST_NONE);
         6'd34: r = mk_step(K_MUL, SRC_C2, SRC_B1, 3'd3, 1'b0, DST_NONE);
         6'd35: r = mk_step(K_MUL, SRC_C2, SRC_B2, 3'd4, 1'b0, DST_NONE);
         6'd36: r = mk_step(K_MUL, SRC_C3, SRC_B0, 3'd3, 1'b0, DST_NONE);
         6'd37: r = mk_step(K_MUL, SRC_C3, SRC_B1, 3'd4, 1'b0, DST_NONE);
         6'd38: r = mk_step(K_MUL, SRC_C3, SRC_B2, 3'd5, 1'b0, DST_R);
         6'd40: r = mk_step(K_CMP, SRC_DAX, SRC_DAX, 3'd0, 1'b0, DST_NONE);
         default: r = mk_step(K_NOP, SRC_DAX, SRC_DAX, 3'd0, 1'b0, DST_NONE);
      endcase
      return r;
   endfunction

endpackage

// ===== sv/pavt_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pavt_mac
// Shared 32x32 multiplier with a limb-shifted wide accumulator.
// ----------------------------------------------------------------------------
module pavt_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [pavt_pkg::LIMB_W-1:0]       x_op,
   input  logic [pavt_pkg::LIMB_W-1:0]       y_op,
   input  pavt_pkg::mac_cmd_type             cmd,
   output pavt_pkg::wb_type                  wb
);

   logic [pavt_pkg::PROD_W-1:0] prod_ff, prod_in;
   pavt_pkg::mac_cmd_type       cmd_ff, cmd_in;
   logic [pavt_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [pavt_pkg::ACC_W-1:0]  addend;

   assign prod_in = {{(pavt_pkg::PROD_W-pavt_pkg::LIMB_W){1'b0}}, x_op} *
                    {{(pavt_pkg::PROD_W-pavt_pkg::LIMB_W){1'b0}}, y_op};
   assign cmd_in  = cmd;

   // partial product lands at limb offset k
   always_comb begin
      addend = {{(pavt_pkg::ACC_W-pavt_pkg::PROD_W){1'b0}}, prod_ff}
               << (pavt_pkg::LIMB_W * cmd_ff.k);
      acc_in = (cmd_ff.first ? '0 : acc_ff) + addend;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd_ff.mul) begin
         acc_ff <= acc_in;
      end
      if (reset) begin
         cmd_ff <= '0;
      end else begin
         cmd_ff <= cmd_in;
      end
   end

   assign wb.we    = cmd_ff.mul && (cmd_ff.dst != pavt_pkg::DST_NONE);
   assign wb.dst   = cmd_ff.dst;
   assign wb.value = acc_in;

endmodule

// ===== sv/pavt_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pavt_eval
// Step sequencer and operand registers for the straightness test of the
// middle point, built around the shared multiplier.
// ----------------------------------------------------------------------------
module pavt_eval (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  pavt_pkg::win_type        win,
   input  pavt_pkg::cfg_type        cfg,
   output pavt_pkg::eval_status_type status
);

   logic                           busy_ff, busy_in;
   logic [pavt_pkg::STEP_W-1:0]    step_ff, step_in;
   logic                           done_ff, done_in;
   logic                           keep_ff, keep_in;
   pavt_pkg::step_type             cur;
   pavt_pkg::mac_cmd_type          cmd;
   pavt_pkg::wb_type               wb;
   logic [pavt_pkg::LIMB_W-1:0]    x_op, y_op;

   logic [31:0]  ax_ff, ay_ff, bx_ff, by_ff;
   logic [64:0]  a_ff, b_ff;
   logic [63:0]  tx_ff, ty_ff;
   logic [33:0]  ct2_ff;
   logic [98:0]  c_ff;
   logic [129:0] d2_ff;
   logic [163:0] r_ff;
   logic [64:0]  d_ff, d_in;
   logic         dot_pos_ff, dot_pos_in;

   logic [pavt_pkg::COORD_W-1:0] dax, day, dbx, dby;
   logic                         axn, ayn, bxn, byn;
   logic [65:0]                  tx_s, ty_s, dot;
   logic                         zero_len, lhs_lt;

   // unsigned deltas and their directions
   assign axn = win.older_col < win.middle_col;
   assign ayn = win.older_row < win.middle_row;
   assign bxn = win.new_col < win.middle_col;
   assign byn = win.new_row < win.middle_row;
   assign dax = axn ? win.middle_col - win.older_col : win.older_col - win.middle_col;
   assign day = ayn ? win.middle_row - win.older_row : win.older_row - win.middle_row;
   assign dbx = bxn ? win.middle_col - win.new_col : win.new_col - win.middle_col;
   assign dby = byn ? win.middle_row - win.new_row : win.new_row - win.middle_row;

   function automatic logic [pavt_pkg::LIMB_W-1:0] pick(input pavt_pkg::src_type s);
      logic [pavt_pkg::LIMB_W-1:0] r;
      case (s)
         pavt_pkg::SRC_DAX:   r = {16'd0, dax};
         pavt_pkg::SRC_DAY:   r = {16'd0, day};
         pavt_pkg::SRC_DBX:   r = {16'd0, dbx};
         pavt_pkg::SRC_DBY:   r = {16'd0, dby};
         pavt_pkg::SRC_PW:    r = {16'd0, cfg.pixel_w};
         pavt_pkg::SRC_PH:    r = {16'd0, cfg.pixel_h};
         pavt_pkg::SRC_AX:    r = ax_ff;
         pavt_pkg::SRC_AY:    r = ay_ff;
         pavt_pkg::SRC_BX:    r = bx_ff;
         pavt_pkg::SRC_BY:    r = by_ff;
         pavt_pkg::SRC_CT:    r = {15'd0, cfg.cos_tol};
         pavt_pkg::SRC_CT2_0: r = ct2_ff[31:0];
         pavt_pkg::SRC_CT2_1: r = {30'd0, ct2_ff[33:32]};
         pavt_pkg::SRC_A0:    r = a_ff[31:0];
         pavt_pkg::SRC_A1:    r = a_ff[63:32];
         pavt_pkg::SRC_A2:    r = {31'd0, a_ff[64]};
         pavt_pkg::SRC_B0:    r = b_ff[31:0];
         pavt_pkg::SRC_B1:    r = b_ff[63:32];
         pavt_pkg::SRC_B2:    r = {31'd0, b_ff[64]};
         pavt_pkg::SRC_C0:    r = c_ff[31:0];
         pavt_pkg::SRC_C1:    r = c_ff[63:32];
         pavt_pkg::SRC_C2:    r = c_ff[95:64];
         pavt_pkg::SRC_C3:    r = {29'd0, c_ff[98:96]};
         pavt_pkg::SRC_D0:    r = d_ff[31:0];
         pavt_pkg::SRC_D1:    r = d_ff[63:32];
         pavt_pkg::SRC_D2:    r = {31'd0, d_ff[64]};
         default:             r = '0;
      endcase
      return r;
   endfunction

   assign cur  = pavt_pkg::step_rom(step_ff);

   always_comb begin
      x_op = pick(cur.xsel);
      y_op = pick(cur.ysel);
   end

   assign cmd.mul   = busy_ff && (cur.kind == pavt_pkg::K_MUL);
   assign cmd.first = cur.first;
   assign cmd.k     = cur.k;
   assign cmd.dst   = cur.dst;

   pavt_mac u_mac (
      .clock (clock),
      .reset (reset),
      .x_op  (x_op),
      .y_op  (y_op),
      .cmd   (cmd),
      .wb    (wb)
   );

   // signed dot product from the two unsigned terms
   always_comb begin
      tx_s = (axn ^ bxn) ? 66'd0 - {2'b00, tx_ff} : {2'b00, tx_ff};
      ty_s = (ayn ^ byn) ? 66'd0 - {2'b00, ty_ff} : {2'b00, ty_ff};
      dot  = tx_s + ty_s;
      dot_pos_in = !dot[65] && (dot != 66'd0);
      d_in = dot[65] ? 65'(66'd0 - dot) : 65'd0;
   end

   assign zero_len = ((ax_ff | ay_ff) == 32'd0) || ((bx_ff | by_ff) == 32'd0);
   assign lhs_lt   = {2'b00, d2_ff, 32'd0} < r_ff;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      done_in = 1'b0;
      keep_in = keep_ff;
      if (busy_ff) begin
         if (cur.kind == pavt_pkg::K_CMP) begin
            keep_in = !zero_len && (dot_pos_ff || lhs_lt);
         end
         if (step_ff == pavt_pkg::LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         step_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff && (cur.kind == pavt_pkg::K_DOT)) begin
         d_ff       <= d_in;
         dot_pos_ff <= dot_pos_in;
      end
      if (wb.we) begin
         case (wb.dst)
            pavt_pkg::DST_AX:  ax_ff  <= wb.value[31:0];
            pavt_pkg::DST_AY:  ay_ff  <= wb.value[31:0];
            pavt_pkg::DST_BX:  bx_ff  <= wb.value[31:0];
            pavt_pkg::DST_BY:  by_ff  <= wb.value[31:0];
            pavt_pkg::DST_A:   a_ff   <= wb.value[64:0];
            pavt_pkg::DST_B:   b_ff   <= wb.value[64:0];
            pavt_pkg::DST_TX:  tx_ff  <= wb.value[63:0];
            pavt_pkg::DST_TY:  ty_ff  <= wb.value[63:0];
            pavt_pkg::DST_CT2: ct2_ff <= wb.value[33:0];
            pavt_pkg::DST_C:   c_ff   <= wb.value[98:0];
            pavt_pkg::DST_D2:  d2_ff  <= wb.value[129:0];
            pavt_pkg::DST_R:   r_ff   <= wb.value[163:0];
            default: ;
         endcase
      end
      keep_ff <= keep_in;
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   assign status.done = done_ff;
   assign status.keep = keep_ff;

endmodule

// ===== sv/pavt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pavt_ctrl
// Request handshake, point window, config registers and the result register.
// ----------------------------------------------------------------------------
module pavt_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [63:0]                     req_tdata,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [63:0]                     rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [pavt_pkg::COS_W-1:0]      csr_wdata,
   output pavt_pkg::win_type               win,
   output pavt_pkg::cfg_type               cfg,
   output logic                            start,
   input  pavt_pkg::eval_status_type       status
);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_ROUTE    = 6'b000010,
      ST_EVAL     = 6'b000100,
      ST_EMIT_MID = 6'b001000,
      ST_SHIFT    = 6'b010000,
      ST_EMIT_NEW = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] seen_ff, seen_in;

   logic [pavt_pkg::COORD_W-1:0] older_col_ff, older_col_in, older_row_ff, older_row_in;
   logic [pavt_pkg::COORD_W-1:0] middle_col_ff, middle_col_in, middle_row_ff, middle_row_in;
   logic [pavt_pkg::VALUE_W-1:0] middle_value_ff, middle_value_in;
   logic [pavt_pkg::COORD_W-1:0] new_col_ff, new_col_in, new_row_ff, new_row_in;
   logic [pavt_pkg::VALUE_W-1:0] new_value_ff, new_value_in;
   logic                         new_eoc_ff, new_eoc_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [pavt_pkg::COORD_W-1:0] rsp_col_ff, rsp_col_in, rsp_row_ff, rsp_row_in;
   logic [pavt_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic [pavt_pkg::COS_W-1:0]   cos_tol_ff;
   logic [pavt_pkg::SCALE_W-1:0] pixel_w_ff, pixel_h_ff;

   logic out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in        = state_ff;
      seen_in         = seen_ff;
      older_col_in    = older_col_ff;
      older_row_in    = older_row_ff;
      middle_col_in   = middle_col_ff;
      middle_row_in   = middle_row_ff;
      middle_value_in = middle_value_ff;
      new_col_in      = new_col_ff;
      new_row_in      = new_row_ff;
      new_value_in    = new_value_ff;
      new_eoc_in      = new_eoc_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_col_in      = rsp_col_ff;
      rsp_row_in      = rsp_row_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_last_in     = rsp_last_ff;
      start           = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               new_col_in   = req_tdata[15:0] & pavt_pkg::COORD_MASK;
               new_row_in   = req_tdata[31:16] & pavt_pkg::COORD_MASK;
               new_value_in = req_tdata[63:32];
               new_eoc_in   = req_tlast;
               state_in     = ST_ROUTE;
            end
         end
         ST_ROUTE: begin
            case (seen_ff)
               2'd0: begin
                  state_in = ST_EMIT_NEW;
               end
               2'd1: begin
                  middle_col_in   = new_col_ff;
                  middle_row_in   = new_row_ff;
                  middle_value_in = new_value_ff;
                  seen_in         = 2'd2;
                  state_in        = new_eoc_ff ? ST_EMIT_NEW : ST_IDLE;
               end
               default: begin
                  start    = 1'b1;
                  state_in = ST_EVAL;
               end
            endcase
         end
         ST_EVAL: begin
            if (status.done) begin
               state_in = status.keep ? ST_EMIT_MID : ST_SHIFT;
            end
         end
         ST_EMIT_MID: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = middle_col_ff;
               rsp_row_in   = middle_row_ff;
               rsp_value_in = middle_value_ff;
               rsp_last_in  = 1'b0;
               state_in     = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            older_col_in    = middle_col_ff;
            older_row_in    = middle_row_ff;
            middle_col_in   = new_col_ff;
            middle_row_in   = new_row_ff;
            middle_value_in = new_value_ff;
            seen_in         = 2'd2;
            state_in        = new_eoc_ff ? ST_EMIT_NEW : ST_IDLE;
         end
         ST_EMIT_NEW: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = new_col_ff;
               rsp_row_in   = new_row_ff;
               rsp_value_in = new_value_ff;
               rsp_last_in  = new_eoc_ff;
               // first point of a chain opens the window, otherwise the chain closes
               if (seen_ff == 2'd0) begin
                  older_col_in = new_col_ff;
                  older_row_in = new_row_ff;
                  seen_in      = new_eoc_ff ? 2'd0 : 2'd1;
               end else begin
                  seen_in = 2'd0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      new_col_ff      <= new_col_in;
      new_row_ff      <= new_row_in;
      new_value_ff    <= new_value_in;
      new_eoc_ff      <= new_eoc_in;
      rsp_col_ff      <= rsp_col_in;
      rsp_row_ff      <= rsp_row_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_last_ff     <= rsp_last_in;
      if (reset) begin
         state_ff        <= ST_IDLE;
         seen_ff         <= 2'd0;
         rsp_valid_ff    <= 1'b0;
         older_col_ff    <= '0;
         older_row_ff    <= '0;
         middle_col_ff   <= '0;
         middle_row_ff   <= '0;
         middle_value_ff <= '0;
         cos_tol_ff      <= pavt_pkg::COS_RESET;
         pixel_w_ff      <= pavt_pkg::SCALE_RESET;
         pixel_h_ff      <= pavt_pkg::SCALE_RESET;
      end else begin
         state_ff        <= state_in;
         seen_ff         <= seen_in;
         rsp_valid_ff    <= rsp_valid_in;
         older_col_ff    <= older_col_in;
         older_row_ff    <= older_row_in;
         middle_col_ff   <= middle_col_in;
         middle_row_ff   <= middle_row_in;
         middle_value_ff <= middle_value_in;
         if (csr_valid) begin
            case (csr_index)
               pavt_pkg::CSR_COS_TOL: cos_tol_ff <= csr_wdata;
               pavt_pkg::CSR_PIXEL_W: pixel_w_ff <= csr_wdata[pavt_pkg::SCALE_W-1:0];
               pavt_pkg::CSR_PIXEL_H: pixel_h_ff <= csr_wdata[pavt_pkg::SCALE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_value_ff, rsp_row_ff, rsp_col_ff};
   assign rsp_tlast  = rsp_last_ff;

   assign win.older_col  = older_col_ff;
   assign win.older_row  = older_row_ff;
   assign win.middle_col = middle_col_ff;
   assign win.middle_row = middle_row_ff;
   assign win.new_col    = new_col_ff;
   assign win.new_row    = new_row_ff;

   assign cfg.cos_tol = cos_tol_ff;
   assign cfg.pixel_w = pixel_w_ff;
   assign cfg.pixel_h = pixel_h_ff;

endmodule

// ===== sv/polyline_angle_vertex_thinning_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_angle_vertex_thinning_top
// Drops near-collinear and degenerate interior points of ordered chains.
// ----------------------------------------------------------------------------
// Points of a chain arrive in order on req, with tlast on the final point of
// the chain; the first and last points of every chain always come out on rsp,
// and rsp_tlast marks the last kept point. The block takes one request at a
// time. The first and second points of a chain are not tested; every later
// point runs the 41-step program of the exact integer straightness test
// through a single shared 32x32 multiplier with a limb-shifted accumulator,
// then emits the middle point if it is kept and the new point if it closes
// the chain, with any wait on rsp. A result held on rsp does not stop the
// next request from being taken. csr registers: 0 cosine tolerance (Q1.16),
// 1 pixel width, 2 pixel height; write them only while the block is idle.
module polyline_angle_vertex_thinning_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [63:0]                req_tdata,   // col[15:0], row[31:16], value[63:32]
   input  logic                       req_tlast,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [63:0]                rsp_tdata,   // kept_col[15:0], kept_row[31:16],
                                                   // kept_value[63:32]
   output logic                       rsp_tlast,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [pavt_pkg::COS_W-1:0] csr_wdata
);

   pavt_pkg::win_type         win;
   pavt_pkg::cfg_type         cfg;
   pavt_pkg::eval_status_type status;
   logic                      start;

   pavt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .win        (win),
      .cfg        (cfg),
      .start      (start),
      .status     (status)
   );

   pavt_eval u_eval (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .win    (win),
      .cfg    (cfg),
      .status (status)
   );

endmodule

// ===== test/tb_polyline_angle_vertex_thinning_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polyline_angle_vertex_thinning_top
// Self-checking bench for the polyline vertex thinning block.
// ----------------------------------------------------------------------------
// Ordered chain points are streamed into req and every kept point on rsp is
// checked against an in-bench model of the three-point window and the exact
// integer straightness test. A directed chain set comes first, then random
// chains under several tolerance and pixel size settings, with random source
// gaps, sink stalls, one long sink hold-off and one full drain mid-phase.
// ----------------------------------------------------------------------------
module tb_polyline_angle_vertex_thinning_top;

   localparam int CLK_HALF      = 2;
   localparam int RESET_CYCLES  = 4;
   localparam int PHASE_POINTS  = 50;
   localparam int NUM_PHASES    = 8;
   localparam int SETTLE_CYCLES = 120;
   localparam int HOLD_CYCLES   = 900;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int MAX_REPORTS   = 10;

   localparam logic [1:0] CSR_SPARE = 2'd3;

   // window fill level
   localparam logic [1:0] CHAIN_IDLE = 2'd0;
   localparam logic [1:0] CHAIN_ONE  = 2'd1;
   localparam logic [1:0] CHAIN_OPEN = 2'd2;

   typedef struct packed {
      logic [15:0] col;
      logic [15:0] row;
      logic [31:0] value;
      logic        last;
   } point_type;

   typedef struct packed {
      logic [15:0] col;
      logic [15:0] row;
      logic [31:0] value;
      logic        done;
   } kept_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [63:0]       req_tdata = '0;
   logic              req_tlast = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [63:0]       rsp_tdata;
   logic              rsp_tlast;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index = pavt_pkg::CSR_COS_TOL;
   logic [pavt_pkg::COS_W-1:0] csr_wdata = '0;

   polyline_angle_vertex_thinning_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #CLK_HALF clock = ~clock;

   point_type points_pending[$];
   kept_type  kept_expected[$];
   point_type drive_pt;

   // register copies
   logic [pavt_pkg::COS_W-1:0]   cfg_cos     = pavt_pkg::COS_RESET;
   logic [pavt_pkg::SCALE_W-1:0] cfg_pixel_w = pavt_pkg::SCALE_RESET;
   logic [pavt_pkg::SCALE_W-1:0] cfg_pixel_h = pavt_pkg::SCALE_RESET;

   // window state
   logic [1:0]  chain_fill  = CHAIN_IDLE;
   logic [15:0] older_col   = '0;
   logic [15:0] older_row   = '0;
   logic [15:0] mid_col     = '0;
   logic [15:0] mid_row     = '0;
   logic [31:0] mid_value   = '0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_orders    = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   logic req_fire     = 1'b0;

   int cycle_count    = 0;
   int fail_count     = 0;
   int points_in      = 0;
   int chains_in      = 0;
   int kept_checked   = 0;
   int thinned_count  = 0;
   int settings_count = 1;

   // scaled |p - q|, neg set when p < q
   function automatic logic [63:0] scaled_gap(input logic [15:0] p, input logic [15:0] q,
                                              input logic [15:0] scale, output bit neg);
      neg = (p < q);
      return (neg ? 64'(q) - 64'(p) : 64'(p) - 64'(q)) * 64'(scale);
   endfunction

   function automatic bit middle_survives(input logic [15:0] ncol, input logic [15:0] nrow);
      bit           axn, ayn, bxn, byn;
      logic [63:0]  axm, aym, bxm, bym;
      logic [255:0] len_a, len_b, tx, ty, pos, neg, diff, lhs, rhs;
      axm = scaled_gap(older_col, mid_col, cfg_pixel_w, axn);
      aym = scaled_gap(older_row, mid_row, cfg_pixel_h, ayn);
      bxm = scaled_gap(ncol, mid_col, cfg_pixel_w, bxn);
      bym = scaled_gap(nrow, mid_row, cfg_pixel_h, byn);
      len_a = 256'(axm) * 256'(axm) + 256'(aym) * 256'(aym);
      len_b = 256'(bxm) * 256'(bxm) + 256'(bym) * 256'(bym);
      if (len_a == 0 || len_b == 0) return 1'b0;
      tx = 256'(axm) * 256'(bxm);
      ty = 256'(aym) * 256'(bym);
      pos = '0;
      neg = '0;
      if (axn != bxn) neg = neg + tx; else pos = pos + tx;
      if (ayn != byn) neg = neg + ty; else pos = pos + ty;
      if (pos > neg) return 1'b1;
      diff = neg - pos;
      lhs = (diff * diff) << 32;
      rhs = 256'(cfg_cos) * 256'(cfg_cos) * len_a * len_b;
      return lhs < rhs;
   endfunction

   task automatic push_kept(input logic [15:0] c, input logic [15:0] r,
                            input logic [31:0] v, input logic done);
      kept_type k;
      k.col   = c;
      k.row   = r;
      k.value = v;
      k.done  = done;
      kept_expected = {kept_expected, k};
   endtask

   task automatic predict_point(input point_type p);
      logic [15:0] c;
      logic [15:0] r;
      c = p.col & pavt_pkg::COORD_MASK;
      r = p.row & pavt_pkg::COORD_MASK;
      if (chain_fill == CHAIN_IDLE) begin
         push_kept(c, r, p.value, p.last);
         older_col  = c;
         older_row  = r;
         chain_fill = p.last ? CHAIN_IDLE : CHAIN_ONE;
      end else begin
         if (chain_fill != CHAIN_ONE) begin
            if (middle_survives(c, r)) push_kept(mid_col, mid_row, mid_value, 1'b0);
            else thinned_count++;
            older_col = mid_col;
            older_row = mid_row;
         end
         mid_col    = c;
         mid_row    = r;
         mid_value  = p.value;
         chain_fill = CHAIN_OPEN;
         if (p.last) begin
            push_kept(c, r, p.value, 1'b1);
            chain_fill = CHAIN_IDLE;
         end
      end
   endtask

   task automatic check_kept(input logic [63:0] data, input logic done);
      kept_type got, want;
      got.col   = data[15:0];
      got.row   = data[31:16];
      got.value = data[63:32];
      got.done  = done;
      if (kept_expected.size() == 0) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("unexpected kept point col %h row %h value %h done %b",
                     got.col, got.row, got.value, got.done);
      end else begin
         want = kept_expected.pop_front();
         kept_checked++;
         if (got.col !== want.col || got.row !== want.row ||
             got.value !== want.value || got.done !== want.done) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
               $display("kept point mismatch: expected col %h row %h value %h done %b",
                        want.col, want.row, want.value, want.done);
               $display("                     got      col %h row %h value %h done %b",
                        got.col, got.row, got.value, got.done);
            end
         end
      end
   endtask

   // monitor and predictor
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("polyline_angle_vertex_thinning_top verification failed");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) check_kept(rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready) begin
            predict_point({req_tdata[15:0], req_tdata[31:16], req_tdata[63:32], req_tlast});
            points_in++;
            if (req_tlast) chains_in++;
         end
         req_fire <= req_tvalid && req_tready;
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (points_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            drive_pt = points_pending.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {drive_pt.value, drive_pt.row, drive_pt.col};
            req_tlast  <= drive_pt.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long sink hold-off, counted here
   always @(negedge clock) begin
      if (hold_orders != hold_served) begin
         hold_left   <= HOLD_CYCLES;
         hold_served <= hold_orders;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   task automatic add_point(input logic [15:0] c, input logic [15:0] r,
                            input logic [31:0] v, input logic last);
      point_type p;
      p.col   = c;
      p.row   = r;
      p.value = v;
      p.last  = last;
      points_pending = {points_pending, p};
   endtask

   // mostly smooth walks so the angle test sees near-straight runs
   task automatic queue_chain(input int n_pts);
      int span, prev_c, prev_r, cur_c, cur_r, nc, nr, k;
      span   = ($urandom_range(0, 4) == 0) ? 65535 : 300;
      cur_c  = $urandom_range(0, span);
      cur_r  = $urandom_range(0, span);
      prev_c = cur_c;
      prev_r = cur_r;
      for (k = 0; k < n_pts; k++) begin
         if (k > 0) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  nc = 2 * cur_c - prev_c + $urandom_range(0, 2) - 1;
                  nr = 2 * cur_r - prev_r + $urandom_range(0, 2) - 1;
               end
               4: begin
                  nc = cur_c;
                  nr = cur_r;
               end
               5: begin
                  nc = prev_c + $urandom_range(0, 4) - 2;
                  nr = prev_r + $urandom_range(0, 4) - 2;
               end
               6: begin
                  nc = $urandom_range(0, 65535);
                  nr = $urandom_range(0, 65535);
               end
               default: begin
                  nc = cur_c + $urandom_range(0, 80) - 40;
                  nr = cur_r + $urandom_range(0, 80) - 40;
               end
            endcase
            prev_c = cur_c;
            prev_r = cur_r;
            cur_c  = nc;
            cur_r  = nr;
         end
         add_point(cur_c[15:0], cur_r[15:0], $urandom, k == n_pts - 1);
      end
   endtask

   task automatic queue_points(input int target);
      int added, n, pick;
      added = 0;
      while (added < target) begin
         pick = $urandom_range(0, 9);
         n = (pick == 0) ? 1 : (pick == 1) ? 2 : $urandom_range(3, 14);
         queue_chain(n);
         added += n;
      end
   endtask

   // empty pipeline, then room for a point that yields nothing
   task automatic wait_drained();
      while (points_pending.size() != 0 || req_tvalid || kept_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [pavt_pkg::COS_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         pavt_pkg::CSR_COS_TOL: cfg_cos     = data;
         pavt_pkg::CSR_PIXEL_W: cfg_pixel_w = data[pavt_pkg::SCALE_W-1:0];
         pavt_pkg::CSR_PIXEL_H: cfg_pixel_h = data[pavt_pkg::SCALE_W-1:0];
         default: ;
      endcase
   endtask

   // pixel writes get a random bit 16, which the register drops
   task automatic apply_setting(input logic [pavt_pkg::COS_W-1:0] cos_tol,
                                input logic [15:0] pw, input logic [15:0] ph);
      write_reg(pavt_pkg::CSR_COS_TOL, cos_tol);
      write_reg(pavt_pkg::CSR_PIXEL_W, {1'($urandom_range(0, 1)), pw});
      write_reg(pavt_pkg::CSR_PIXEL_H, {1'($urandom_range(0, 1)), ph});
      settings_count++;
   endtask

   initial begin : stimulus
      int ph;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed chains under reset settings
      add_point(16'd0, 16'd0, 32'h8000_0000, 1'b1);
      add_point(16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 1'b0);
      add_point(16'd0, 16'd0, 32'hFFFF_FFFF, 1'b1);
      add_point(16'd0, 16'd0, $urandom, 1'b0);
      add_point(16'd1, 16'd0, $urandom, 1'b0);
      add_point(16'd2, 16'd0, $urandom, 1'b0);
      add_point(16'd3, 16'd0, $urandom, 1'b1);
      // repeated point, zero length segment
      add_point(16'd5, 16'd5, $urandom, 1'b0);
      add_point(16'd5, 16'd5, $urandom, 1'b0);
      add_point(16'd6, 16'd7, $urandom, 1'b1);
      add_point(16'd10, 16'd10, $urandom, 1'b0);
      add_point(16'd20, 16'd10, $urandom, 1'b0);
      add_point(16'd20, 16'd20, $urandom, 1'b1);
      // doubling back, positive dot
      add_point(16'd0, 16'd0, $urandom, 1'b0);
      add_point(16'd100, 16'd0, $urandom, 1'b0);
      add_point(16'd1, 16'd1, $urandom, 1'b1);
      add_point(16'd0, 16'd0, $urandom, 1'b0);
      add_point(16'hFFFF, 16'hFFFF, $urandom, 1'b0);
      add_point(16'd0, 16'hFFFF, $urandom, 1'b0);
      add_point(16'hFFFF, 16'd0, $urandom, 1'b1);
      add_point(16'd0, 16'd0, $urandom, 1'b0);
      add_point(16'd1000, 16'd1, $urandom, 1'b0);
      add_point(16'd2000, 16'd0, $urandom, 1'b1);
      wait_drained();

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: apply_setting(17'd65536, 16'd1, 16'd1);
            1: apply_setting(17'd0, 16'hFFFF, 16'hFFFF);
            2: apply_setting(17'h1FFFF, 16'd3, 16'd7);
            3: apply_setting(17'($urandom_range(60000, 65535)), 16'd0,
                             16'($urandom_range(1, 65535)));
            4: apply_setting(17'd65535, 16'($urandom_range(1, 65535)), 16'd0);
            5: apply_setting(17'($urandom_range(0, 131071)), 16'($urandom_range(1, 300)),
                             16'($urandom_range(1, 300)));
            6: begin
               apply_setting(pavt_pkg::COS_RESET, pavt_pkg::SCALE_RESET,
                             pavt_pkg::SCALE_RESET);
               write_reg(CSR_SPARE, 17'($urandom));
            end
            default: apply_setting(17'($urandom_range(64000, 65536)), 16'hFFFF, 16'd1);
         endcase
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         if (ph == 4) begin
            // sink holds off while the source keeps pushing
            queue_points(PHASE_POINTS);
            hold_orders++;
         end else if (ph == 5) begin
            queue_points(PHASE_POINTS / 2);
            wait_drained();
            queue_points(PHASE_POINTS / 2);
         end else begin
            queue_points(PHASE_POINTS);
         end
         wait_drained();
      end

      if (kept_expected.size() != 0) begin
         $display("%0d kept points never arrived", kept_expected.size());
         fail_count += kept_expected.size();
      end
      $display("run: %0d points in %0d chains over %0d register settings",
               points_in, chains_in, settings_count);
      $display("run: %0d kept points checked, %0d interior points thinned, %0d mismatches",
               kept_checked, thinned_count, fail_count);
      if (fail_count == 0)
         $display("polyline_angle_vertex_thinning_top verification clean");
      else
         $display("polyline_angle_vertex_thinning_top verification failed");
      $finish;
   end

endmodule
